// ===== rtl/aesks_pkg.sv =====
// package for the aes-128 round key step
// holds the s-box, the round constant table and the stage type; no dependencies
package aesks_pkg;

    localparam int unsigned RconCount = 10;

    // s-box as a constant table, 256 entries of one byte
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [RconCount] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // payload carried down the pipe
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] temp;
        logic        bad;
    } stage_t;

endpackage

// ===== rtl/aes128_round_key_step.sv =====
// top level of the aes-128 round key step
// depends on aesks_pkg for the s-box, round constants and stage type
//
// One item in, one item out: the next AES-128 round key from the previous one
// and a round index. Items may enter in every cycle while the output is not
// stalled. There are three register stages. Stage one rotates the last word
// and looks it up in the s-box, stage two adds the round constant and forms
// the first two words, stage three forms the last two.
// The pipeline advances whenever its final register is empty or being taken,
// so a stall holds every stage in place and nothing is lost or repeated.
// A round index above 9 uses a zero round constant and sets bad_round.
module aes128_round_key_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // prev_key_hi, prev_key_lo, round_index, 4 zero bits
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // next_key_hi, next_key_lo, bad_round, 7 zero bits
);
    import aesks_pkg::*;

    logic       v1_reg, v2_reg, v3_reg;
    stage_t     s1_reg, s1_next, s2_reg, s2_next;
    logic [3:0] idx1_reg;
    logic [127:0] key3_reg, key3_next;
    logic       bad3_reg;
    logic       adv;

    logic [63:0] in_hi, in_lo;
    logic [3:0]  in_idx;
    logic [31:0] rot;
    logic [7:0]  rc;

    // whole pipe moves together unless the output item is stuck
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign in_hi  = s_tdata[63:0];
    assign in_lo  = s_tdata[127:64];
    assign in_idx = s_tdata[131:128];

    // stage one: rotate and substitute
    always_comb
    begin
        rot        = {in_lo[23:0], in_lo[31:24]};
        s1_next.w0 = in_hi[63:32];
        s1_next.w1 = in_hi[31:0];
        s1_next.w2 = in_lo[63:32];
        s1_next.w3 = in_lo[31:0];
        s1_next.temp = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        s1_next.bad  = (in_idx > 4'd9);
    end

    // stage two: round constant, first two words
    always_comb
    begin
        rc = s1_reg.bad ? 8'h00 : RCON[idx1_reg];
        s2_next      = s1_reg;
        s2_next.w0   = s1_reg.temp ^ {rc, 24'h0} ^ s1_reg.w0;
        s2_next.w1   = s2_next.w0 ^ s1_reg.w1;
    end

    // stage three: last two words
    always_comb
    begin
        key3_next[127:96] = s2_reg.w0;
        key3_next[95:64]  = s2_reg.w1;
        key3_next[63:32]  = s2_reg.w1 ^ s2_reg.w2;
        key3_next[31:0]   = s2_reg.w1 ^ s2_reg.w2 ^ s2_reg.w3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= s1_next;
            idx1_reg <= in_idx;
            s2_reg   <= s2_next;
            key3_reg <= key3_next;
            bad3_reg <= s2_reg.bad;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {7'h0, bad3_reg, key3_reg[63:0], key3_reg[127:64]};

`ifndef SYNTH
    // a stalled result keeps its key
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");
    // an accepted item shows up at the output when no stall intervenes
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 adv ##1 adv |=> m_tvalid)
        else $error("item lost in pipe");
    // flag raised only for indices above 9
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (s1_reg.bad == (idx1_reg > 4'd9)))
        else $error("bad round flag wrong");
`endif

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for aes128_round_key_step
// depends on aesks_pkg only for the round constant count; predicts each next key in-house
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aesks_pkg::RconCount;

    localparam int unsigned LatencyCycles = 3;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned RandomItems = 1450;

    // idling phases: each sets how often the sender gaps and the receiver stalls
    typedef enum logic [1:0] {PH_SEND_IDLE, PH_RECV_IDLE, PH_NO_IDLE} idle_phase_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [3:0]  idx;
    } prev_key_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        bad;
    } next_key_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;      // prev_key_hi, prev_key_lo, round_index, zero fill from bit 0 up
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;      // next_key_hi, next_key_lo, bad_round, zero fill from bit 0 up

    aes128_round_key_step dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // own copy of the s-box and round constants
    logic [7:0] sub_byte [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    logic [7:0] round_const [RconCount] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    prev_key_t   pending_keys [$];   // items waiting for the driver
    next_key_t   expected_keys [$];  // predicted next keys, oldest first
    idle_phase_t idle_phase;
    bit          sender_pause;       // driver holds off until all keys have come
    bit          long_hold;          // receiver holds off for a long stretch
    int unsigned hold_count;
    int unsigned cycle_count;
    int unsigned mismatch_count;

    // one key expansion step
    function automatic next_key_t expand_key(prev_key_t k);
        logic [31:0] w0, w1, w2, w3, rot, temp, n0, n1, n2, n3;
        logic [7:0]  rc;
        next_key_t   r;
        w0 = k.hi[63:32];
        w1 = k.hi[31:0];
        w2 = k.lo[63:32];
        w3 = k.lo[31:0];
        // out-of-range index: zero round constant and flag raised
        r.bad = (k.idx >= RconCount);
        rc = r.bad ? 8'h00 : round_const[k.idx];
        rot = {w3[23:0], w3[31:24]};
        temp = {sub_byte[rot[31:24]] ^ rc, sub_byte[rot[23:16]],
                sub_byte[rot[15:8]], sub_byte[rot[7:0]]};
        n0 = temp ^ w0;
        n1 = n0 ^ w1;
        n2 = n1 ^ w2;
        n3 = n2 ^ w3;
        r.hi = {n0, n1};
        r.lo = {n2, n3};
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_key(logic [63:0] hi, logic [63:0] lo, logic [3:0] idx);
        prev_key_t k;
        k.hi = hi;
        k.lo = lo;
        k.idx = idx;
        pending_keys.push_back(k);
    endtask

    task automatic wait_drained();
        while (pending_keys.size() != 0 || s_tvalid || expected_keys.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sender side: present the head of the queue, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            // the item on the bus (if any) is taken at this edge
            if (pending_keys.size() != 0 && !sender_pause &&
                !(idle_phase == PH_SEND_IDLE && $urandom_range(99) < 6) &&
                !(idle_phase == PH_RECV_IDLE && $urandom_range(99) < 78))
            begin
                prev_key_t k;
                k = pending_keys.pop_front();
                s_tvalid <= 1'b1;
                // high half lowest, then low half, then round index
                s_tdata  <= {4'h0, k.idx, k.lo, k.hi};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // prediction at acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            prev_key_t k;
            k.hi  = s_tdata[63:0];
            k.lo  = s_tdata[127:64];
            k.idx = s_tdata[131:128];
            expected_keys.push_back(expand_key(k));
        end
    end

    // receiver side: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_count <= 0;
        end
        else if (long_hold && hold_count < 300)
        begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end
        else if (idle_phase == PH_SEND_IDLE)
            m_tready <= ($urandom_range(99) >= 78);
        else if (idle_phase == PH_RECV_IDLE)
            m_tready <= ($urandom_range(99) >= 6);
        else
            m_tready <= 1'b1;
    end

    // result checking against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            next_key_t got, want;
            got.hi  = m_tdata[63:0];
            got.lo  = m_tdata[127:64];
            got.bad = m_tdata[128];
            if (expected_keys.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected key hi=%h lo=%h bad=%b", got.hi, got.lo, got.bad);
            end
            else
            begin
                want = expected_keys.pop_front();
                if (got.hi !== want.hi || got.lo !== want.lo || got.bad !== want.bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("key mismatch: want hi=%h lo=%h bad=%b, got hi=%h lo=%h bad=%b",
                                 want.hi, want.lo, want.bad, got.hi, got.lo, got.bad);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        cycle_count    = 0;
        mismatch_count = 0;
        idle_phase     = PH_SEND_IDLE;
        sender_pause   = 1'b0;
        long_hold      = 1'b0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every round index, extremes of the key halves
        for (int i = 0; i < 16; i++)
            queue_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, i[3:0]);
        queue_key('0, '0, 4'd0);
        queue_key('1, '1, 4'd9);
        queue_key('1, '1, 4'd15);
        queue_key('0, '1, 4'd10);
        queue_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 4'd7);
        queue_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 4'd8);

        // first phase: sender mostly busy, receiver stalls often
        for (n = 0; n < RandomItems / 3; n++)
            queue_key(rand64(), rand64(), 4'($urandom_range(15)));
        // receiver holds off long enough that the pipe fills and input stalls
        long_hold <= 1'b1;
        wait_drained();

        idle_phase = PH_RECV_IDLE;
        for (n = 0; n < RandomItems / 3; n++)
            queue_key(rand64(), rand64(), 4'($urandom_range(15)));
        // sender pauses mid-stream until every expected key has arrived
        repeat (100) @(posedge clk);
        sender_pause = 1'b1;
        while (s_tvalid || expected_keys.size() != 0)
            @(posedge clk);
        repeat (LatencyCycles + 2) @(posedge clk);
        sender_pause = 1'b0;
        wait_drained();

        idle_phase = PH_NO_IDLE;
        for (n = 0; n < RandomItems - 2 * (RandomItems / 3); n++)
            queue_key(rand64(), rand64(), 4'($urandom_range(15)));
        wait_drained();

        repeat (LatencyCycles + 5) @(posedge clk);
        if (mismatch_count == 0 && expected_keys.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
